// ===== hw/rtl/lqf_pkg.sv =====
// Shared types and constants for the link quality failover block.
// Holds the link state codes, the register indexes and the controller/datapath structs.
// No dependencies.
package lqf_pkg;

    localparam int CFG_W      = 8;   // width of every configuration register
    localparam int CFG_IDX_W  = 3;   // width of the register index
    localparam int RSSI_W     = 8;
    localparam int STATE_W    = 2;
    localparam int S_TDATA_W  = 16;  // rssi + wifi_up, padded to whole bytes
    localparam int M_TDATA_W  = 8;   // link_state, padded to a byte

    typedef enum logic [STATE_W-1:0] {
        LINK_NORMAL   = 2'd0,
        LINK_WARNING  = 2'd1,
        LINK_FALLBACK = 2'd2
    } link_state_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_SECS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REQ_GOOD    = 3'd4;

    // Register reset values
    localparam logic signed [CFG_W-1:0] UPPER_THR_RST   = -8'sd65;
    localparam logic signed [CFG_W-1:0] LOWER_THR_RST   = -8'sd80;
    localparam logic [CFG_W-1:0]        STABLE_SECS_RST = 8'd10;
    localparam logic [CFG_W-1:0]        WINDOW_SIZE_RST = 8'd20;
    localparam logic [CFG_W-1:0]        REQ_GOOD_RST    = 8'd15;

    localparam logic [CFG_W-1:0] SECS_MAX = 8'd255;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the accepted input item
        logic apply;     // tick or store-and-compare for the held item
        logic scan;      // one step of the window scan
        logic decide;    // close the scan, return to normal if enough good samples
        logic load_out;  // move the link state into the output register
    } lqf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_scan;  // warning may return to normal: good count required
        logic scan_done;  // every filled window slot read and counted
        logic out_busy;   // output register holds a result not yet taken
    } lqf_sts_t;

endpackage

// ===== hw/rtl/lqf_ctrl.sv =====
// Sequencing controller for the link quality failover block.
// Depends on lqf_pkg for the command and status structs.
module lqf_ctrl import lqf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  lqf_sts_t sts,
    output lqf_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_OUT
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        ready_reg, ready_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY;
                    ready_next  = 1'b0;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = sts.need_scan ? ST_SCAN : ST_OUT;
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                    ready_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

// ===== hw/rtl/lqf_dp.sv =====
// Datapath of the link quality failover block: registers, sample window, scan counter.
// Depends on lqf_pkg for codes, register indexes and the command and status structs.
module lqf_dp import lqf_pkg::*;
#(
    parameter int MAX_SAMPLES = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_mode,
    input  logic signed [RSSI_W-1:0] in_rssi,
    input  logic                     in_up,
    input  lqf_cmd_t                 cmd,
    output lqf_sts_t                 sts,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output logic [STATE_W-1:0]       link_state
);

    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    // configuration
    logic signed [CFG_W-1:0] upper_thr_reg, lower_thr_reg;
    logic [CFG_W-1:0]        stable_secs_reg, window_size_reg, req_good_reg;

    // held item
    logic                     item_mode_reg;
    logic signed [RSSI_W-1:0] item_rssi_reg;
    logic                     item_up_reg;

    // link state and counters
    link_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   widx_reg, widx_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CFG_W-1:0]   secs_reg, secs_next;

    // scan
    logic [CNT_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]   scan_lim_reg, scan_lim_next;
    logic [CNT_W-1:0]   good_reg, good_next;
    logic               rd_pend_reg, rd_pend_next;
    logic signed [RSSI_W-1:0] rd_data_reg;

    // output
    logic               out_valid_reg, out_valid_next;
    logic [STATE_W-1:0] out_state_reg;

    logic signed [RSSI_W-1:0] win_mem [MAX_SAMPLES];

    logic [CNT_W-1:0] cap;
    logic [IDX_W-1:0] wslot;
    logic [CNT_W-1:0] wslot_inc;
    logic [CNT_W-1:0] fill_after;
    logic             mem_we;
    logic             below_upper, below_lower;

    always_comb
    begin
        cap = (window_size_reg < CFG_W'(MAX_SAMPLES)) ? CNT_W'(window_size_reg)
                                                      : CNT_W'(MAX_SAMPLES);
        // a stale write position at or past the capacity wraps to slot zero
        wslot      = (CNT_W'(widx_reg) >= cap) ? '0 : widx_reg;
        wslot_inc  = CNT_W'(wslot) + CNT_W'(1);
        fill_after = (cap != '0 && fill_reg < cap) ? fill_reg + CNT_W'(1) : fill_reg;
        below_upper = item_rssi_reg < upper_thr_reg;
        below_lower = item_rssi_reg < lower_thr_reg;
        mem_we = cmd.apply && !item_mode_reg && (cap != '0);

        sts.need_scan = !item_mode_reg && (state_reg == LINK_WARNING) && item_up_reg
                        && !below_lower && !below_upper
                        && (secs_reg >= stable_secs_reg)
                        && (CFG_W'(fill_after) >= window_size_reg);
        sts.scan_done = !rd_pend_reg && (scan_addr_reg >= scan_lim_reg);
        sts.out_busy  = out_valid_reg && !m_tready;
    end

    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        fill_next      = fill_reg;
        secs_next      = secs_reg;
        scan_addr_next = scan_addr_reg;
        scan_lim_next  = scan_lim_reg;
        good_next      = good_reg;
        rd_pend_next   = rd_pend_reg;

        if (cmd.apply)
        begin
            scan_addr_next = '0;
            scan_lim_next  = (fill_after < cap) ? fill_after : cap;
            good_next      = '0;
            rd_pend_next   = 1'b0;
            if (item_mode_reg)
            begin
                if (secs_reg != SECS_MAX)
                begin
                    secs_next = secs_reg + CFG_W'(1);
                end
            end
            else
            begin
                if (cap != '0)
                begin
                    widx_next = (wslot_inc >= cap) ? '0 : IDX_W'(wslot_inc);
                    fill_next = fill_after;
                end
                unique case (state_reg)
                    LINK_NORMAL:
                    begin
                        if (!item_up_reg || below_upper)
                        begin
                            state_next = LINK_WARNING;
                        end
                    end
                    LINK_WARNING:
                    begin
                        if (!item_up_reg || below_lower)
                        begin
                            state_next = LINK_FALLBACK;
                        end
                    end
                    LINK_FALLBACK:
                    begin
                        if (item_up_reg && !below_upper)
                        begin
                            state_next = LINK_WARNING;
                        end
                    end
                    default:
                    begin
                        state_next = LINK_NORMAL;
                    end
                endcase
            end
        end

        if (cmd.scan)
        begin
            if (scan_addr_reg < scan_lim_reg)
            begin
                scan_addr_next = scan_addr_reg + CNT_W'(1);
                rd_pend_next   = 1'b1;
            end
            else
            begin
                rd_pend_next = 1'b0;
            end
            if (rd_pend_reg && !(rd_data_reg < upper_thr_reg))
            begin
                good_next = good_reg + CNT_W'(1);
            end
        end

        if (cmd.decide && (CFG_W'(good_reg) >= req_good_reg))
        begin
            state_next = LINK_NORMAL;
        end

        // entering a state clears the window fill, write position and seconds
        if (state_next != state_reg)
        begin
            widx_next = '0;
            fill_next = '0;
            secs_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_thr_reg   <= UPPER_THR_RST;
            lower_thr_reg   <= LOWER_THR_RST;
            stable_secs_reg <= STABLE_SECS_RST;
            window_size_reg <= WINDOW_SIZE_RST;
            req_good_reg    <= REQ_GOOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UPPER_THR:   upper_thr_reg   <= cfg_data;
                REG_LOWER_THR:   lower_thr_reg   <= cfg_data;
                REG_STABLE_SECS: stable_secs_reg <= cfg_data;
                REG_WINDOW_SIZE: window_size_reg <= cfg_data;
                REG_REQ_GOOD:    req_good_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LINK_NORMAL;
            widx_reg      <= '0;
            fill_reg      <= '0;
            secs_reg      <= '0;
            scan_addr_reg <= '0;
            scan_lim_reg  <= '0;
            good_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            fill_reg      <= fill_next;
            secs_reg      <= secs_next;
            scan_addr_reg <= scan_addr_next;
            scan_lim_reg  <= scan_lim_next;
            good_reg      <= good_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_mode_reg <= in_mode;
            item_rssi_reg <= in_rssi;
            item_up_reg   <= in_up;
        end
        if (cmd.load_out)
        begin
            out_state_reg <= state_reg;
        end
    end

    // sample window: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[wslot] <= item_rssi_reg;
        end
        rd_data_reg <= win_mem[scan_addr_reg[IDX_W-1:0]];
    end

    assign m_tvalid   = out_valid_reg;
    assign link_state = out_state_reg;

endmodule

// ===== hw/rtl/link_quality_failover_fsm.sv =====
// Top level of the link quality failover block.
// Depends on lqf_pkg, lqf_ctrl and lqf_dp.
//
// Channel  Direction  Handshake           Payload
// -------  ---------  ------------------  --------------------------------------------
// s_*      in         s_tvalid/s_tready   tuser: mode; tdata: rssi[7:0], wifi_up[8]
// m_*      out        m_tvalid/m_tready   tdata: link_state[1:0], zero above
// cfg_*    in         cfg_we              cfg_index selects register, cfg_data value
//
// A tick, or a sample needing no window check, goes through capture, apply and load.
// A sample in warning that is up, at or above both thresholds and meets the seconds
// and fill tests also scans min(fill, capacity) window slots between apply and load,
// one slot a cycle through a registered read port.
// Reset clears counters, sets link state normal, loads register defaults; window unknown.
// A stalled result lets one more transaction in; hold that one until the result is taken.
module link_quality_failover_fsm import lqf_pkg::*;
#(
    parameter int MAX_SAMPLES = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // sample and tick stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] rssi, [8] wifi_up, rest zero
    input  logic                   s_tuser,   // [0] mode: 0 sample, 1 tick
    // link state stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // [1:0] link_state, rest zero
);

    lqf_cmd_t           cmd;
    lqf_sts_t           sts;
    logic [STATE_W-1:0] link_state;

    // Sequence one transaction at a time: capture, apply, optional scan, load.
    lqf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold configuration, link state, window and output register.
    lqf_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_mode    (s_tuser),
        .in_rssi    (s_tdata[RSSI_W-1:0]),
        .in_up      (s_tdata[RSSI_W]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .link_state (link_state)
    );

    // Pad the link state to a whole byte.
    assign m_tdata = {{(M_TDATA_W-STATE_W){1'b0}}, link_state};

endmodule
